/* src/rsp_pkg.sv */
package rsp_pkg;

  localparam int MAX_SITES  = 1024;
  localparam int SITE_W     = $clog2(MAX_SITES);
  localparam int LEN_W      = SITE_W + 1;
  localparam int RL_W       = 11;
  localparam int THR_W      = 32;
  localparam int CNT_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [RL_W-1:0]  RL_RESET  = RL_W'(1024);
  localparam logic [CNT_W-1:0] HPC_RESET = CNT_W'(2);

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_START,
    OP_UPDATE
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_LENGTH,
    CFG_CREATION,
    CFG_ANNIHILATION,
    CFG_MOVEMENT,
    CFG_HALF_PASS_COUNT
  } cfg_idx_t;

  localparam logic [1:0] FC_MOVE       = 2'd0;
  localparam logic [1:0] FC_CREATE     = 2'd1;
  localparam logic [1:0] FC_ANNIHILATE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [THR_W-1:0] creation;
    logic [THR_W-1:0] annihilation;
    logic [THR_W-1:0] movement;
    logic [CNT_W-1:0] half_pass_count;
    logic             len_wr;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [SITE_W-1:0] site;
    logic              spin;
    logic              flipped;
    logic [1:0]        flip_case;
    logic              half_pass_done;
    logic              group_done;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [SITE_W-1:0] waddr;
    logic              wdata;
    logic [SITE_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [RL_W-1:0] rl);
    logic [RL_W-1:0] even;
    logic [LEN_W-1:0] len;
    even = {rl[RL_W-1:1], 1'b0};
    if (32'(even) < 32'd4) begin
      len = LEN_W'(4);
    end else if (32'(even) > 32'(MAX_SITES)) begin
      len = LEN_W'(MAX_SITES);
    end else begin
      len = LEN_W'(even);
    end
    return len;
  endfunction

  function automatic logic [SITE_W-1:0] first_site(input logic parity,
                                                   input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] top;
    top = len - LEN_W'(1);
    return parity ? '0 : top[SITE_W-1:0];
  endfunction

endpackage

/* src/rsp_ram.sv */
module rsp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/rsp_cfg.sv */
module rsp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rsp_pkg::cfg_t                    cfg
);
  import rsp_pkg::*;

  logic [RL_W-1:0]  ring_length_r;
  logic [THR_W-1:0] creation_r;
  logic [THR_W-1:0] annihilation_r;
  logic [THR_W-1:0] movement_r;
  logic [CNT_W-1:0] hpc_r;
  logic             len_wr_r;
  logic             wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_length_r  <= RL_RESET;
      creation_r     <= '0;
      annihilation_r <= '0;
      movement_r     <= '0;
      hpc_r          <= HPC_RESET;
      len_wr_r       <= 1'b0;
    end else begin
      len_wr_r <= wr && (cfg_index == CFG_RING_LENGTH);
      if (wr) begin
        case (cfg_index)
          CFG_RING_LENGTH:     ring_length_r  <= cfg_data[RL_W-1:0];
          CFG_CREATION:        creation_r     <= cfg_data[THR_W-1:0];
          CFG_ANNIHILATION:    annihilation_r <= cfg_data[THR_W-1:0];
          CFG_MOVEMENT:        movement_r     <= cfg_data[THR_W-1:0];
          CFG_HALF_PASS_COUNT: hpc_r          <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.len             = eff_len(ring_length_r);
    cfg.creation        = creation_r;
    cfg.annihilation    = annihilation_r;
    cfg.movement        = movement_r;
    cfg.half_pass_count = hpc_r;
    cfg.len_wr          = len_wr_r;
  end

endmodule

/* src/rsp_core.sv */
module rsp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic [rsp_pkg::SITE_W-1:0]    index,
  input  logic                          spin_in,
  input  logic                          start_parity,
  input  logic [rsp_pkg::THR_W-1:0]     uniform,
  input  rsp_pkg::cfg_t                 cfg,
  output rsp_pkg::mem_req_t             mem,
  input  logic                          mem_rdata,
  output rsp_pkg::res_t                 res
);
  import rsp_pkg::*;

  state_t            state_r, state_nxt;
  op_t               op_r;
  logic [SITE_W-1:0] idx_r;
  logic              spin_in_r;
  logic              sp_r;
  logic [THR_W-1:0]  uniform_r;
  logic [SITE_W-1:0] c_r;
  logic              lft_r;
  logic              rgt_r;
  logic [SITE_W-1:0] cursor_r;
  logic              parity_r;
  logic [CNT_W-1:0]  hpc_r;
  logic [SITE_W-1:0] clr_cnt_r;
  res_t              res_r;
  res_t              res_nxt;

  logic [SITE_W-1:0] len_m1;
  logic [SITE_W-1:0] c_calc;
  logic [SITE_W-1:0] lft_addr;
  logic [SITE_W-1:0] rgt_addr;
  logic              s;
  logic [1:0]        fcase;
  logic [THR_W-1:0]  thr;
  logic              flip;
  logic [SITE_W-1:0] last;
  logic              hdone;
  logic [CNT_W:0]    cnt_inc;
  logic              gdone;
  logic [SITE_W-1:0] cursor_nxt;
  logic              accept;
  logic [LEN_W-1:0]  len_m1_w;

  assign accept   = start && !busy;
  assign len_m1_w = cfg.len - LEN_W'(1);
  assign len_m1   = len_m1_w[SITE_W-1:0];

  always_comb begin
    case (op_r)
      OP_START:  c_calc = first_site(sp_r, cfg.len);
      OP_UPDATE: begin
        if ((LEN_W'(cursor_r) >= cfg.len) || (cursor_r[0] == parity_r)) begin
          c_calc = first_site(parity_r, cfg.len);
        end else begin
          c_calc = cursor_r;
        end
      end
      default:   c_calc = idx_r;
    endcase
    lft_addr = (c_calc == '0) ? len_m1 : c_calc - SITE_W'(1);
    rgt_addr = (c_r == len_m1) ? '0 : c_r + SITE_W'(1);
  end

  always_comb begin
    s = mem_rdata;
    if (lft_r == rgt_r) begin
      fcase = (lft_r == s) ? FC_CREATE : FC_ANNIHILATE;
      thr   = (lft_r == s) ? cfg.creation : cfg.annihilation;
    end else begin
      fcase = FC_MOVE;
      thr   = cfg.movement;
    end
    flip    = uniform_r < thr;
    last    = parity_r ? len_m1 - SITE_W'(1) : len_m1 - SITE_W'(2);
    hdone   = c_r == last;
    cnt_inc = {1'b0, hpc_r} + (CNT_W+1)'(1);
    gdone   = hdone && (cnt_inc >= {1'b0, cfg.half_pass_count});
    if (hdone) begin
      cursor_nxt = first_site(!parity_r, cfg.len);
    end else if (!parity_r && (c_r == len_m1)) begin
      cursor_nxt = SITE_W'(1);
    end else begin
      cursor_nxt = c_r + SITE_W'(2);
    end
  end

  always_comb begin
    res_nxt = '0;
    if (state_r == ST_EXEC) begin
      res_nxt.valid = 1'b1;
      res_nxt.site  = c_r;
      case (op_r)
        OP_WRITE:  res_nxt.spin = spin_in_r;
        OP_UPDATE: begin
          res_nxt.spin           = s ^ flip;
          res_nxt.flipped        = flip;
          res_nxt.flip_case      = fcase;
          res_nxt.half_pass_done = hdone;
          res_nxt.group_done     = gdone;
        end
        default:   res_nxt.spin = s;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    mem.we    = 1'b0;
    mem.waddr = c_r;
    mem.wdata = 1'b0;
    mem.raddr = c_r;
    case (state_r)
      ST_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = clr_cnt_r;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        mem.raddr = (op_r == OP_UPDATE) ? lft_addr : c_calc;
        state_nxt = (op_r == OP_UPDATE) ? ST_RD1 : ST_EXEC;
      end
      ST_RD1: begin
        mem.raddr = rgt_addr;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_r == OP_WRITE) begin
          mem.we    = 1'b1;
          mem.wdata = spin_in_r;
        end else if (op_r == OP_UPDATE && flip) begin
          mem.we    = 1'b1;
          mem.wdata = !s;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= op_t'(op);
      idx_r     <= index;
      spin_in_r <= spin_in;
      sp_r      <= start_parity;
      uniform_r <= uniform;
    end
    if (state_r == ST_RD0) begin
      c_r <= c_calc;
    end
    if (state_r == ST_RD1) begin
      lft_r <= mem_rdata;
    end
    if (state_r == ST_RD2) begin
      rgt_r <= mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= first_site(1'b0, eff_len(RL_RESET));
      parity_r  <= 1'b0;
      hpc_r     <= '0;
      clr_cnt_r <= '0;
      res_r     <= '0;
    end else begin
      res_r <= res_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SITE_W'(1);
      end
      if (state_r == ST_EXEC) begin
        case (op_r)
          OP_START: begin
            parity_r <= sp_r;
            hpc_r    <= '0;
            cursor_r <= c_r;
          end
          OP_UPDATE: begin
            cursor_r <= cursor_nxt;
            if (hdone) begin
              parity_r <= !parity_r;
              hpc_r    <= gdone ? '0 : cnt_inc[CNT_W-1:0];
            end
          end
          default: ;
        endcase
      end else if (cfg.len_wr) begin
        cursor_r <= first_site(parity_r, cfg.len);
      end
    end
  end

  assign res = res_r;

endmodule

/* src/ring_spin_parity_flip_update.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | start, busy          | in_op, in_index, in_spin_in, in_start_parity,
//         |           |                      | in_uniform
// out     | output    | out_valid (strobe)   | out_site, out_spin_out, out_flipped,
//         |           |                      | out_flip_case, out_half_pass_done, out_group_done
// cfg     | input     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// Update: steps through states RD0, RD1, RD2 and EXEC with busy high, then strobes its result;
// it is paced by the single read port of the spin memory (left, right and center read in turn).
// Write, read and start group: step through states RD0 and EXEC with busy high.
// After reset a clearing pass zeroes all 1024 sites of the spin memory with busy high;
// configuration writes are taken during it.
// Results are strobed for one cycle; the receiver cannot stall.
module ring_spin_parity_flip_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic [rsp_pkg::SITE_W-1:0]    in_index,
  input  logic                          in_spin_in,
  input  logic                          in_start_parity,
  input  logic [rsp_pkg::THR_W-1:0]     in_uniform,
  output logic                          out_valid,
  output logic [rsp_pkg::SITE_W-1:0]    out_site,
  output logic                          out_spin_out,
  output logic                          out_flipped,
  output logic [1:0]                    out_flip_case,
  output logic                          out_half_pass_done,
  output logic                          out_group_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rsp_pkg::*;

  cfg_t     cfg;
  mem_req_t mem;
  logic     mem_rdata;
  res_t     res;

  rsp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsp_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SITES)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

  rsp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .op           (in_op),
    .index        (in_index),
    .spin_in      (in_spin_in),
    .start_parity (in_start_parity),
    .uniform      (in_uniform),
    .cfg          (cfg),
    .mem          (mem),
    .mem_rdata    (mem_rdata),
    .res          (res)
  );

  assign out_valid          = res.valid;
  assign out_site           = res.site;
  assign out_spin_out       = res.spin;
  assign out_flipped        = res.flipped;
  assign out_flip_case      = res.flip_case;
  assign out_half_pass_done = res.half_pass_done;
  assign out_group_done     = res.group_done;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_group_in_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_group_done |-> out_half_pass_done && out_valid)
    else $error("group end without half-pass end");

  a_flip_case_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_flip_case == FC_MOVE || out_flip_case == FC_CREATE ||
                  out_flip_case == FC_ANNIHILATE)
    else $error("bad flip case");

endmodule
